// File: rtl/fuhs_pkg.sv
package fuhs_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned StuckW = 5;
  localparam int unsigned ActW   = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [StuckW-1:0] STUCK_LIMIT = 5'd20;

  // phases
  localparam logic [PhaseW-1:0] PH_BOOT      = 4'd0;
  localparam logic [PhaseW-1:0] PH_ERASE     = 4'd1;
  localparam logic [PhaseW-1:0] PH_WRITE     = 4'd2;
  localparam logic [PhaseW-1:0] PH_PKT_SEND  = 4'd3;
  localparam logic [PhaseW-1:0] PH_PKT_CHECK = 4'd4;
  localparam logic [PhaseW-1:0] PH_CRC_SEND  = 4'd5;
  localparam logic [PhaseW-1:0] PH_CRC_CHECK = 4'd6;
  localparam logic [PhaseW-1:0] PH_FINISH    = 4'd7;
  localparam logic [PhaseW-1:0] PH_APP_IDLE  = 4'd8;

  // actions
  localparam logic [ActW-1:0] ACT_NONE = 2'd0;
  localparam logic [ActW-1:0] ACT_CMD  = 2'd1;
  localparam logic [ActW-1:0] ACT_DATA = 2'd2;
  localparam logic [ActW-1:0] ACT_CRC  = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_LAST_PACKET_INDEX = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CMD_BOOT_MODE     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CMD_ERASE         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CMD_WRITE         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CMD_FINISH        = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RESP_READY        = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RESP_OK           = 3'd6;

  typedef struct packed {
    logic [WordW-1:0] last_packet_index;
    logic [WordW-1:0] cmd_boot_mode;
    logic [WordW-1:0] cmd_erase;
    logic [WordW-1:0] cmd_write;
    logic [WordW-1:0] cmd_finish;
    logic [WordW-1:0] resp_ready;
    logic [WordW-1:0] resp_ok;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [StuckW-1:0] stuck;
    logic [WordW-1:0]  pkt_cnt;
    logic              act_led;
    logic              done_led;
  } seq_state_t;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [WordW-1:0]  command_code;
    logic [WordW-1:0]  packet_index;
    logic              activity_led;
    logic              done_led;
    logic [PhaseW-1:0] phase;
  } result_t;

endpackage

// File: rtl/fuhs_step_if.sv
interface fuhs_step_if;
  logic                        valid;
  logic                        ready;
  logic [fuhs_pkg::WordW-1:0]  response;

  modport source (output valid, output response, input ready);
  modport sink   (input valid, input response, output ready);
endinterface

// File: rtl/fuhs_result_if.sv
interface fuhs_result_if;
  logic                         valid;
  logic                         ready;
  logic [fuhs_pkg::ActW-1:0]    action;
  logic [fuhs_pkg::WordW-1:0]   command_code;
  logic [fuhs_pkg::WordW-1:0]   packet_index;
  logic                         activity_led;
  logic                         done_led;
  logic [fuhs_pkg::PhaseW-1:0]  phase;

  modport source (
    output valid, output action, output command_code, output packet_index,
    output activity_led, output done_led, output phase, input ready
  );
  modport sink (
    input valid, input action, input command_code, input packet_index,
    input activity_led, input done_led, input phase, output ready
  );
endinterface

// File: rtl/fuhs_cfg_regs.sv
module fuhs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fuhs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fuhs_pkg::WordW-1:0]     cfg_data,
  output fuhs_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_packet_index <= 16'd0;
      cfg.cmd_boot_mode     <= 16'd1;
      cfg.cmd_erase         <= 16'd2;
      cfg.cmd_write         <= 16'd3;
      cfg.cmd_finish        <= 16'd4;
      cfg.resp_ready        <= 16'd0;
      cfg.resp_ok           <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fuhs_pkg::REG_LAST_PACKET_INDEX: cfg.last_packet_index <= cfg_data;
        fuhs_pkg::REG_CMD_BOOT_MODE:     cfg.cmd_boot_mode     <= cfg_data;
        fuhs_pkg::REG_CMD_ERASE:         cfg.cmd_erase         <= cfg_data;
        fuhs_pkg::REG_CMD_WRITE:         cfg.cmd_write         <= cfg_data;
        fuhs_pkg::REG_CMD_FINISH:        cfg.cmd_finish        <= cfg_data;
        fuhs_pkg::REG_RESP_READY:        cfg.resp_ready        <= cfg_data;
        fuhs_pkg::REG_RESP_OK:           cfg.resp_ok           <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fuhs_step_logic.sv
module fuhs_step_logic (
  input  fuhs_pkg::cfg_t               cfg,
  input  fuhs_pkg::seq_state_t         st,
  input  logic [fuhs_pkg::WordW-1:0]   response,
  output fuhs_pkg::seq_state_t         st_next,
  output fuhs_pkg::result_t            res
);

  logic                          ok;
  logic [fuhs_pkg::PhaseW-1:0]   phase_next;
  logic [fuhs_pkg::StuckW-1:0]   stuck_inc;

  assign ok = (response == cfg.resp_ok);

  always_comb begin
    st_next          = st;
    phase_next       = st.phase;
    res.action       = fuhs_pkg::ACT_NONE;
    res.command_code = '0;
    res.packet_index = '0;

    unique case (st.phase)
      fuhs_pkg::PH_BOOT: begin
        st_next.pkt_cnt  = '0;
        res.action       = fuhs_pkg::ACT_CMD;
        res.command_code = cfg.cmd_boot_mode;
        if (response == cfg.resp_ready) phase_next = fuhs_pkg::PH_ERASE;
      end
      fuhs_pkg::PH_ERASE: begin
        res.action       = fuhs_pkg::ACT_CMD;
        res.command_code = cfg.cmd_erase;
        if (ok) phase_next = fuhs_pkg::PH_WRITE;
      end
      fuhs_pkg::PH_WRITE: begin
        res.action       = fuhs_pkg::ACT_CMD;
        res.command_code = cfg.cmd_write;
        if (ok) phase_next = fuhs_pkg::PH_PKT_SEND;
      end
      fuhs_pkg::PH_PKT_SEND: begin
        res.action       = fuhs_pkg::ACT_DATA;
        res.packet_index = st.pkt_cnt;
        st_next.act_led  = ~st.act_led;
        phase_next       = fuhs_pkg::PH_PKT_CHECK;
      end
      fuhs_pkg::PH_PKT_CHECK: begin
        if (ok && (st.pkt_cnt >= cfg.last_packet_index)) begin
          phase_next = fuhs_pkg::PH_CRC_SEND;
        end else begin
          if (ok) st_next.pkt_cnt = st.pkt_cnt + 16'd1;
          phase_next = fuhs_pkg::PH_PKT_SEND;
        end
      end
      fuhs_pkg::PH_CRC_SEND: begin
        res.action = fuhs_pkg::ACT_CRC;
        phase_next = fuhs_pkg::PH_CRC_CHECK;
      end
      fuhs_pkg::PH_CRC_CHECK: begin
        phase_next = ok ? fuhs_pkg::PH_FINISH : fuhs_pkg::PH_CRC_SEND;
      end
      fuhs_pkg::PH_FINISH: begin
        res.action       = fuhs_pkg::ACT_CMD;
        res.command_code = cfg.cmd_finish;
        st_next.act_led  = 1'b0;
        if (ok) begin
          phase_next       = fuhs_pkg::PH_APP_IDLE;
          st_next.done_led = 1'b1;
        end
      end
      fuhs_pkg::PH_APP_IDLE: begin
        st_next.done_led = ~st.done_led;
      end
      default: phase_next = fuhs_pkg::PH_BOOT;
    endcase

    // stuck watchdog; the idle phase never counts
    stuck_inc = st.stuck + 5'd1;
    if (phase_next != st.phase) begin
      st_next.stuck = '0;
      st_next.phase = phase_next;
    end else if (st.phase == fuhs_pkg::PH_APP_IDLE) begin
      st_next.stuck = '0;
      st_next.phase = phase_next;
    end else if (stuck_inc > fuhs_pkg::STUCK_LIMIT) begin
      st_next.stuck = '0;
      st_next.phase = fuhs_pkg::PH_BOOT;
    end else begin
      st_next.stuck = stuck_inc;
      st_next.phase = phase_next;
    end

    res.activity_led = st_next.act_led;
    res.done_led     = st_next.done_led;
    res.phase        = st_next.phase;
  end

endmodule

// File: rtl/flash_update_host_sequencer.sv
// Flash update host sequencer. Each step item carries the target's response word and yields
// one result item: the action to perform (command, data packet, CRC packet or none), the
// command code, the packet index, both LED levels and the phase after the step. Items may be
// offered back to back; the result sits in an output register, and a new step is accepted
// whenever that register is empty or being emptied, so throughput is one item per clock
// while results are taken. The user must write registers via cfg_we/cfg_index/cfg_data only
// while no step is in flight (not enforced); indexes beyond the last register are ignored.
module flash_update_host_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fuhs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fuhs_pkg::WordW-1:0]    cfg_data,
  fuhs_step_if.sink                     step,
  fuhs_result_if.source                 result
);

  fuhs_pkg::cfg_t        cfg;
  fuhs_pkg::seq_state_t  st;
  fuhs_pkg::seq_state_t  st_next;
  fuhs_pkg::result_t     res_next;
  fuhs_pkg::result_t     res;
  logic                  out_valid;
  logic                  take;

  fuhs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fuhs_step_logic u_step (
    .cfg      (cfg),
    .st       (st),
    .response (step.response),
    .st_next  (st_next),
    .res      (res_next)
  );

  assign step.ready = !out_valid || result.ready;
  assign take       = step.valid && step.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) st <= st_next;
      if (take) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

  assign result.valid        = out_valid;
  assign result.action       = res.action;
  assign result.command_code = res.command_code;
  assign result.packet_index = res.packet_index;
  assign result.activity_led = res.activity_led;
  assign result.done_led     = res.done_led;
  assign result.phase        = res.phase;

  a_stuck_bound: assert property (@(posedge clk) disable iff (rst)
    st.stuck <= fuhs_pkg::STUCK_LIMIT)
    else $error("stuck count beyond limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    take |-> (!out_valid || result.ready))
    else $error("pending result overwritten");

  a_data_then_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.action == fuhs_pkg::ACT_DATA) |-> res.phase == fuhs_pkg::PH_PKT_CHECK)
    else $error("data packet not followed by check phase");

  a_code_only_on_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.action != fuhs_pkg::ACT_CMD) |-> res.command_code == '0)
    else $error("command code without command action");

endmodule

// File: bench/tb_flash_update_host_sequencer.sv
module tb_flash_update_host_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [fuhs_pkg::CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam logic [fuhs_pkg::WordW-1:0]   WordMax    = 16'hFFFF;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 60;

  // register settings used between update runs
  localparam int unsigned SET_RANDOM      = 0;
  localparam int unsigned SET_ZERO        = 1;
  localparam int unsigned SET_MAX         = 2;
  localparam int unsigned SET_SHARED_RESP = 3;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_we    = 1'b0;
  logic [fuhs_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [fuhs_pkg::WordW-1:0]   cfg_data  = '0;

  fuhs_step_if   step_ch ();
  fuhs_result_if result_ch ();

  flash_update_host_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step_ch),
    .result    (result_ch)
  );

  always #5ns clk = ~clk;

  fuhs_pkg::cfg_t             seq_cfg;
  fuhs_pkg::seq_state_t       seq_st;
  fuhs_pkg::result_t          predicted_actions[$];
  logic [fuhs_pkg::WordW-1:0] response_words[$];

  int unsigned tx_max_gap = 0;
  int unsigned rx_max_gap = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned steps_sent = 0;
  int unsigned results_seen = 0;
  int unsigned runs_finished = 0;
  int unsigned runs_abandoned = 0;
  logic [8:0]  phases_reached = '0;

  // One step of the sequencer: updates the mirrored state, returns the action item.
  function automatic fuhs_pkg::result_t advance_sequencer(logic [fuhs_pkg::WordW-1:0] resp);
    fuhs_pkg::result_t           r;
    logic [fuhs_pkg::PhaseW-1:0] nxt;
    logic                        ok;
    r   = '0;
    ok  = (resp == seq_cfg.resp_ok);
    nxt = seq_st.phase;
    case (seq_st.phase)
      fuhs_pkg::PH_BOOT: begin
        seq_st.pkt_cnt = '0;
        r.action       = fuhs_pkg::ACT_CMD;
        r.command_code = seq_cfg.cmd_boot_mode;
        if (resp == seq_cfg.resp_ready) nxt = fuhs_pkg::PH_ERASE;
      end
      fuhs_pkg::PH_ERASE: begin
        r.action       = fuhs_pkg::ACT_CMD;
        r.command_code = seq_cfg.cmd_erase;
        if (ok) nxt = fuhs_pkg::PH_WRITE;
      end
      fuhs_pkg::PH_WRITE: begin
        r.action       = fuhs_pkg::ACT_CMD;
        r.command_code = seq_cfg.cmd_write;
        if (ok) nxt = fuhs_pkg::PH_PKT_SEND;
      end
      fuhs_pkg::PH_PKT_SEND: begin
        r.action       = fuhs_pkg::ACT_DATA;
        r.packet_index = seq_st.pkt_cnt;
        seq_st.act_led = ~seq_st.act_led;
        nxt            = fuhs_pkg::PH_PKT_CHECK;
      end
      fuhs_pkg::PH_PKT_CHECK: begin
        if (!ok) begin
          nxt = fuhs_pkg::PH_PKT_SEND;
        end else if (seq_st.pkt_cnt >= seq_cfg.last_packet_index) begin
          nxt = fuhs_pkg::PH_CRC_SEND;
        end else begin
          seq_st.pkt_cnt = seq_st.pkt_cnt + 1'b1;
          nxt            = fuhs_pkg::PH_PKT_SEND;
        end
      end
      fuhs_pkg::PH_CRC_SEND: begin
        r.action = fuhs_pkg::ACT_CRC;
        nxt      = fuhs_pkg::PH_CRC_CHECK;
      end
      fuhs_pkg::PH_CRC_CHECK: nxt = ok ? fuhs_pkg::PH_FINISH : fuhs_pkg::PH_CRC_SEND;
      fuhs_pkg::PH_FINISH: begin
        r.action       = fuhs_pkg::ACT_CMD;
        r.command_code = seq_cfg.cmd_finish;
        seq_st.act_led = 1'b0;
        if (ok) begin
          nxt             = fuhs_pkg::PH_APP_IDLE;
          seq_st.done_led = 1'b1;
        end
      end
      fuhs_pkg::PH_APP_IDLE: seq_st.done_led = ~seq_st.done_led;
      default: nxt = fuhs_pkg::PH_BOOT;
    endcase
    // app idle never times out
    if (nxt != seq_st.phase || seq_st.phase == fuhs_pkg::PH_APP_IDLE) begin
      seq_st.stuck = '0;
    end else begin
      seq_st.stuck = seq_st.stuck + 1'b1;
      if (seq_st.stuck > fuhs_pkg::STUCK_LIMIT) begin
        nxt          = fuhs_pkg::PH_BOOT;
        seq_st.stuck = '0;
      end
    end
    seq_st.phase   = nxt;
    r.activity_led = seq_st.act_led;
    r.done_led     = seq_st.done_led;
    r.phase        = nxt;
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [fuhs_pkg::WordW-1:0] got,
                             logic [fuhs_pkg::WordW-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             results_seen, name, got, want));
  endtask

  task automatic write_reg(logic [fuhs_pkg::CfgIdxW-1:0] idx,
                           logic [fuhs_pkg::WordW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fuhs_pkg::REG_LAST_PACKET_INDEX: seq_cfg.last_packet_index = val;
      fuhs_pkg::REG_CMD_BOOT_MODE:     seq_cfg.cmd_boot_mode     = val;
      fuhs_pkg::REG_CMD_ERASE:         seq_cfg.cmd_erase         = val;
      fuhs_pkg::REG_CMD_WRITE:         seq_cfg.cmd_write         = val;
      fuhs_pkg::REG_CMD_FINISH:        seq_cfg.cmd_finish        = val;
      fuhs_pkg::REG_RESP_READY:        seq_cfg.resp_ready        = val;
      fuhs_pkg::REG_RESP_OK:           seq_cfg.resp_ok           = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(int unsigned flavour);
    logic [fuhs_pkg::WordW-1:0]   val;
    logic [fuhs_pkg::CfgIdxW-1:0] idx;
    for (int i = 0; i <= int'(fuhs_pkg::REG_RESP_OK); i++) begin
      idx = fuhs_pkg::CfgIdxW'(i);
      case (flavour)
        SET_ZERO: val = '0;
        SET_MAX:  val = WordMax;
        default: begin
          case ($urandom_range(0, 5))
            0:       val = '0;
            1:       val = WordMax;
            default: val = fuhs_pkg::WordW'($urandom);
          endcase
          if (idx == fuhs_pkg::REG_LAST_PACKET_INDEX)
            val = fuhs_pkg::WordW'($urandom_range(0, 4));
        end
      endcase
      write_reg(idx, val);
    end
    if (flavour == SET_SHARED_RESP) write_reg(fuhs_pkg::REG_RESP_READY, seq_cfg.resp_ok);
    write_reg(REG_UNUSED, fuhs_pkg::WordW'($urandom));
  endtask

  // sender holds back until every predicted item has come out
  task automatic wait_idle();
    while (response_words.size() != 0 || step_ch.valid || predicted_actions.size() != 0)
      @(negedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // a word that neither accepts nor signals ready
  function automatic logic [fuhs_pkg::WordW-1:0] refused_word();
    logic [fuhs_pkg::WordW-1:0] w;
    do begin
      case ($urandom_range(0, 3))
        0:       w = '0;
        1:       w = WordMax;
        default: w = fuhs_pkg::WordW'($urandom);
      endcase
    end while (w == seq_cfg.resp_ok || w == seq_cfg.resp_ready);
    return w;
  endfunction

  // erase/write/finish style wait; returns 1 when the run is left to time out
  function automatic bit queue_retry_phase(bit may_abort);
    int unsigned refusals;
    case ($urandom_range(0, 7))
      0:       refusals = may_abort ? int'(fuhs_pkg::STUCK_LIMIT) + 1
                                    : int'(fuhs_pkg::STUCK_LIMIT);
      1:       refusals = int'(fuhs_pkg::STUCK_LIMIT);
      default: refusals = $urandom_range(0, 4);
    endcase
    repeat (refusals) response_words.push_back(refused_word());
    if (refusals > int'(fuhs_pkg::STUCK_LIMIT)) return 1'b1;
    response_words.push_back(seq_cfg.resp_ok);
    return 1'b0;
  endfunction

  function automatic void queue_packets(int unsigned count);
    repeat (count) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
        response_words.push_back(fuhs_pkg::WordW'($urandom));
        response_words.push_back(refused_word());
      end
      response_words.push_back(fuhs_pkg::WordW'($urandom));
      response_words.push_back(seq_cfg.resp_ok);
    end
  endfunction

  function automatic bit queue_entry(bit may_abort);
    // boot refusals, sometimes past the stuck limit (boot just restarts itself)
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(15, 30) : $urandom_range(0, 3))
      response_words.push_back(refused_word());
    response_words.push_back(seq_cfg.resp_ready);
    if (queue_retry_phase(may_abort) || queue_retry_phase(may_abort)) begin
      runs_abandoned++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_tail(bit complete);
    queue_packets(1);  // CRC send and check have the same shape as a data packet
    if (complete) begin
      void'(queue_retry_phase(1'b0));
      runs_finished++;
    end else begin
      repeat (int'(fuhs_pkg::STUCK_LIMIT) + 1) response_words.push_back(refused_word());
      runs_abandoned++;
    end
  endfunction

  always @(posedge clk) begin : step_driver
    logic offer;
    if (rst) begin
      step_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      offer = step_ch.valid;
      if (step_ch.valid && step_ch.ready) begin
        predicted_actions.push_back(advance_sequencer(step_ch.response));
        phases_reached[seq_st.phase] = 1'b1;
        steps_sent++;
        offer   = 1'b0;
        tx_wait = $urandom_range(0, tx_max_gap);
      end else if (!step_ch.valid && tx_wait != 0) begin
        tx_wait--;
      end
      if (!offer && tx_wait == 0 && response_words.size() != 0) begin
        step_ch.response <= response_words.pop_front();
        offer = 1'b1;
      end else if (!offer) begin
        step_ch.response <= fuhs_pkg::WordW'($urandom);
      end
      step_ch.valid <= offer;
    end
  end

  always @(posedge clk) begin : result_monitor
    logic take;
    fuhs_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      take = result_ch.ready;
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (predicted_actions.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing predicted", results_seen));
        end else begin
          want = predicted_actions.pop_front();
          check_field("action", result_ch.action, want.action);
          check_field("command_code", result_ch.command_code, want.command_code);
          check_field("packet_index", result_ch.packet_index, want.packet_index);
          check_field("activity_led", result_ch.activity_led, want.activity_led);
          check_field("done_led", result_ch.done_led, want.done_led);
          check_field("phase", result_ch.phase, want.phase);
        end
        rx_wait = $urandom_range(0, rx_max_gap);
        take    = (rx_wait == 0);
      end else if (!result_ch.ready) begin
        if (hold_left != 0) hold_left--;
        else if (rx_wait != 0) rx_wait--;
        take = (hold_left == 0 && rx_wait == 0);
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HoldCycles;
        take      = 1'b0;
      end
      result_ch.ready <= take;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (step_ch.valid && step_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no item moved for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    step_ch.valid    = 1'b0;
    step_ch.response = '0;
    result_ch.ready  = 1'b0;
    seq_cfg = '{last_packet_index: 16'd0, cmd_boot_mode: 16'd1, cmd_erase: 16'd2,
                cmd_write: 16'd3, cmd_finish: 16'd4, resp_ready: 16'd0, resp_ok: 16'd1};
    seq_st  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk at reset settings, back to back: one refusal in each waiting
    // phase, a packet resend, a CRC resend, then a stuck timeout out of finish
    response_words = '{WordMax, seq_cfg.resp_ready, 16'h0000, seq_cfg.resp_ok,
                       16'h7FFF, seq_cfg.resp_ok, WordMax, 16'h8000, 16'h0000,
                       seq_cfg.resp_ok, 16'h5555, 16'hAAAA, 16'h1234, seq_cfg.resp_ok,
                       16'hFFFE};
    repeat (int'(fuhs_pkg::STUCK_LIMIT)) response_words.push_back(refused_word());

    for (int run = 0; run < 9; run++) begin
      wait_idle();
      if (run == 4) load_settings(SET_ZERO);
      else if (run % 3 == 2) load_settings(SET_SHARED_RESP);
      else if (run != 0) load_settings(SET_RANDOM);
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (run % 4 == 2) begin
        // receiver stalls while the sender keeps pushing
        tx_max_gap = 0;
        hold_requests++;
      end
      if (!queue_entry(1'b1)) begin
        queue_packets(int'(seq_cfg.last_packet_index) + 1);
        queue_tail(1'b0);
      end
    end

    // largest image: a few packets, then the bound is pulled to or below the counter
    wait_idle();
    load_settings(SET_MAX);
    tx_max_gap = 8;
    rx_max_gap = 8;
    void'(queue_entry(1'b0));
    queue_packets(6);
    wait_idle();
    write_reg(fuhs_pkg::REG_LAST_PACKET_INDEX, fuhs_pkg::WordW'($urandom_range(0, 6)));
    queue_packets(1);
    queue_tail(1'b0);

    // one update to completion, then a long app idle stretch
    wait_idle();
    load_settings(SET_RANDOM);
    void'(queue_entry(1'b0));
    queue_packets(int'(seq_cfg.last_packet_index) + 1);
    queue_tail(1'b1);
    repeat (30) response_words.push_back(fuhs_pkg::WordW'($urandom));

    wait_idle();
    repeat (4) @(posedge clk);
    $display("%0d steps, %0d results checked; %0d update runs finished, %0d abandoned",
             steps_sent, results_seen, runs_finished, runs_abandoned);
    $display("phases reached %b, long receiver stalls %0d", phases_reached, holds_served);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
